[design/tccb_pkg.sv]
// Shared types and character codes for the text console cell buffer.
package tccb_pkg;

  localparam logic [7:0] CODE_BS    = 8'd8;
  localparam logic [7:0] CODE_LF    = 8'd10;
  localparam logic [7:0] CODE_FF    = 8'd12;
  localparam logic [7:0] CODE_CR    = 8'd13;
  localparam logic [7:0] CODE_DEL   = 8'd127;
  localparam logic [7:0] SPACE_CODE = 8'd32;
  localparam logic [7:0] GLYPH_LAST = 8'd151;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_code;
    logic [5:0] read_row;
    logic [5:0] read_col;
  } item_t;

  typedef struct packed {
    logic       redraw_one;
    logic [5:0] redraw_row;
    logic       redraw_all;
    logic [5:0] cursor_col;
    logic [5:0] cursor_row;
    logic [7:0] cell_char;
    logic [6:0] glyph_index;
  } result_t;

  typedef enum logic [2:0] {
    K_READ,
    K_CR,
    K_LF,
    K_ERASE,
    K_CLEAR,
    K_PUT,
    K_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] code;
    logic [5:0] row;
    logic [5:0] col;
  } cmd_t;

endpackage

[design/text_console_cell_buffer_core.sv]
// Top level of the text console cell buffer: front end, queue and executor.
//
// Text console core. Each transfer on the input (start high while busy is
// low) carries either a character to put or a cell to read, and produces
// exactly one result, shown on result for one cycle with done high; the
// receiver cannot stall, so sample result whenever done is high. After reset
// the block clears its TEXT_ROWS x TEXT_COLS cell store to spaces in a
// clearing pass, with busy held high. Items pass through a two-entry queue
// into the executor, which owns the single cell memory port and the cursor.
// A put, carriage return, line feed, backspace or ignored control code gives
// its result through the queue entry and the result register; a read also
// passes through the registered memory read. A line feed or printable
// character that scrolls blanks one row through the memory port; a form feed
// blanks the whole store. Up to two items may be queued behind a busy
// executor; busy rises when the queue is full.
module text_console_cell_buffer_core #(
  parameter int TEXT_COLS = 40,
  parameter int TEXT_ROWS = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tccb_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  output tccb_pkg::result_t result
);
  import tccb_pkg::*;

  logic full;
  logic clearing;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_valid;
  cmd_t q_cmd;

  // classify the incoming transfer; hold it off while the queue is full or the store is clearing
  tccb_front u_front (
    .start    (start),
    .item     (item),
    .full     (full),
    .clearing (clearing),
    .busy     (busy),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouple acceptance from long scroll and clear sweeps
  tccb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .valid    (q_valid),
    .head     (q_cmd)
  );

  // execute commands against the cell store and advance the cursor
  tccb_back #(
    .TEXT_COLS (TEXT_COLS),
    .TEXT_ROWS (TEXT_ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .clearing (clearing),
    .done     (done),
    .result   (result)
  );

endmodule

[design/tccb_front.sv]
// Front end: accept items and classify them into console commands.
module tccb_front (
  input  logic            start,
  input  tccb_pkg::item_t item,
  input  logic            full,
  input  logic            clearing,
  output logic            busy,
  output logic            push,
  output tccb_pkg::cmd_t  push_cmd
);
  import tccb_pkg::*;

  assign busy = full || clearing;
  assign push = start && !busy;

  always_comb begin
    push_cmd.code = item.char_code;
    push_cmd.row  = item.read_row;
    push_cmd.col  = item.read_col;
    priority if (item.operation == OP_READ) begin
      push_cmd.kind = K_READ;
    end else if (item.char_code == CODE_CR) begin
      push_cmd.kind = K_CR;
    end else if (item.char_code == CODE_LF) begin
      push_cmd.kind = K_LF;
    end else if (item.char_code == CODE_BS || item.char_code == CODE_DEL) begin
      push_cmd.kind = K_ERASE;
    end else if (item.char_code == CODE_FF) begin
      push_cmd.kind = K_CLEAR;
    end else if (item.char_code >= SPACE_CODE) begin
      push_cmd.kind = K_PUT;
    end else begin
      push_cmd.kind = K_NOP;
    end
  end

endmodule

[design/tccb_queue.sv]
// Two-entry command queue between the front end and the executor.
module tccb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tccb_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output tccb_pkg::cmd_t head
);
  import tccb_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W+1)'(DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/tccb_back.sv]
// Executor: cell store, cursor, scroll and clear sweeps, result register.
module tccb_back #(
  parameter int TEXT_COLS = 40,
  parameter int TEXT_ROWS = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  tccb_pkg::cmd_t    q_cmd,
  output logic              pop,
  output logic              clearing,
  output logic              done,
  output tccb_pkg::result_t result
);
  import tccb_pkg::*;

  localparam int CELL_COUNT = TEXT_ROWS * TEXT_COLS;
  localparam int ROW_W      = $clog2(TEXT_ROWS);
  localparam int COL_W      = $clog2(TEXT_COLS);
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(TEXT_ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(TEXT_COLS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_END   = ADDR_W'(TEXT_COLS - 1);
  localparam logic [ROW_W:0]    ROWS_WIDE = (ROW_W+1)'(TEXT_ROWS);

  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_READ = 5'b00100,
    ST_ROW  = 5'b01000,
    ST_ALL  = 5'b10000
  } state_t;

  state_t             state, state_next;
  logic [COL_W-1:0]   col, col_next;
  logic [ROW_W-1:0]   line, line_next;
  logic [ROW_W-1:0]   top, top_next;
  logic [ADDR_W-1:0]  sweep, sweep_next;

  logic [7:0]         mem [CELL_COUNT];
  logic [7:0]         rdata;
  logic               we;
  logic [7:0]         wdata;
  logic [ADDR_W-1:0]  mem_addr;
  logic               use_sweep;

  logic [ROW_W-1:0]   a_row;
  logic [COL_W-1:0]   a_col;
  logic [ROW_W:0]     phys_sum;
  logic [ROW_W-1:0]   phys;
  logic [ADDR_W-1:0]  cell_addr;

  logic               emit;
  logic               r_one;
  logic [5:0]         r_row;
  logic               r_all;
  logic [7:0]         r_char;
  logic [6:0]         r_glyph;
  logic               in_range;

  assign clearing = (state == ST_INIT);

  // logical row to physical row through the circular top pointer
  assign phys_sum  = {1'b0, top} + {1'b0, a_row};
  assign phys      = (phys_sum >= ROWS_WIDE) ? ROW_W'(phys_sum - ROWS_WIDE)
                                             : ROW_W'(phys_sum);
  assign cell_addr = ADDR_W'(phys * TEXT_COLS) + ADDR_W'(a_col);
  assign mem_addr  = use_sweep ? sweep : cell_addr;

  assign in_range = (32'(q_cmd.row) < TEXT_ROWS) && (32'(q_cmd.col) < TEXT_COLS);

  always_comb begin
    state_next = state;
    col_next   = col;
    line_next  = line;
    top_next   = top;
    sweep_next = sweep;
    we         = 1'b0;
    wdata      = SPACE_CODE;
    use_sweep  = 1'b0;
    a_row      = '0;
    a_col      = '0;
    pop        = 1'b0;
    emit       = 1'b0;
    r_one      = 1'b0;
    r_row      = '0;
    r_all      = 1'b0;
    r_char     = '0;
    r_glyph    = '0;
    unique case (state)
      ST_INIT, ST_ALL: begin
        use_sweep = 1'b1;
        we        = 1'b1;
        if (sweep == LAST_CELL) begin
          sweep_next = '0;
          state_next = ST_IDLE;
          emit       = (state == ST_ALL);
          r_all      = 1'b1;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          unique case (q_cmd.kind)
            K_READ: begin
              if (in_range) begin
                a_row      = ROW_W'(q_cmd.row);
                a_col      = COL_W'(q_cmd.col);
                state_next = ST_READ;
              end else begin
                emit = 1'b1;
              end
            end
            K_CR: begin
              col_next = '0;
              emit     = 1'b1;
            end
            K_LF: begin
              col_next = '0;
              if (line == LAST_ROW) begin
                state_next = ST_ROW;
              end else begin
                line_next = line + 1'b1;
                emit      = 1'b1;
              end
            end
            K_ERASE: begin
              emit = 1'b1;
              if (col != '0) begin
                col_next = col - 1'b1;
                a_row    = line;
                a_col    = col - 1'b1;
                we       = 1'b1;
                r_one    = 1'b1;
                r_row    = 6'(line);
              end
            end
            K_CLEAR: begin
              top_next   = '0;
              col_next   = '0;
              line_next  = '0;
              state_next = ST_ALL;
            end
            K_PUT: begin
              a_row = line;
              a_col = col;
              we    = 1'b1;
              wdata = q_cmd.code;
              if (col == LAST_COL) begin
                col_next = '0;
                if (line == LAST_ROW) begin
                  state_next = ST_ROW;
                end else begin
                  line_next = line + 1'b1;
                  emit      = 1'b1;
                  r_one     = 1'b1;
                  r_row     = 6'(line);
                end
              end else begin
                col_next = col + 1'b1;
                emit     = 1'b1;
                r_one    = 1'b1;
                r_row    = 6'(line);
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_ROW: begin
        // blank the old top row, then advance the top pointer
        a_row = '0;
        a_col = COL_W'(sweep);
        we    = 1'b1;
        if (sweep == ROW_END) begin
          sweep_next = '0;
          top_next   = (top == LAST_ROW) ? '0 : top + 1'b1;
          state_next = ST_IDLE;
          emit       = 1'b1;
          r_all      = 1'b1;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      ST_READ: begin
        emit       = 1'b1;
        r_char     = rdata;
        state_next = ST_IDLE;
        if (rdata >= SPACE_CODE && rdata <= GLYPH_LAST) begin
          r_glyph = 7'(rdata - SPACE_CODE);
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[mem_addr] <= wdata;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    result.redraw_one  <= r_one;
    result.redraw_row  <= r_row;
    result.redraw_all  <= r_all;
    result.cursor_col  <= 6'(col_next);
    result.cursor_row  <= 6'(line_next);
    result.cell_char   <= r_char;
    result.glyph_index <= r_glyph;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      col   <= '0;
      line  <= '0;
      top   <= '0;
      sweep <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      col   <= col_next;
      line  <= line_next;
      top   <= top_next;
      sweep <= sweep_next;
      done  <= emit;
    end
  end

`ifndef SYNTHESIS
  a_redraw_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.redraw_one && result.redraw_all))
    else $error("redraw_one and redraw_all both set");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(col) < TEXT_COLS) && (32'(line) < TEXT_ROWS) && (32'(top) < TEXT_ROWS))
    else $error("cursor or top pointer out of range");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> (q_valid && state == ST_IDLE))
    else $error("pop without a queued command");

  a_glyph_char: assert property (@(posedge clk) disable iff (rst)
    (done && result.glyph_index != '0) |-> (result.cell_char > SPACE_CODE))
    else $error("glyph index without a matching cell code");

  a_no_done_in_init: assert property (@(posedge clk) disable iff (rst)
    $past(state == ST_INIT) |-> !done)
    else $error("result during the reset clearing pass");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the text console cell buffer core.
module tb_top;
  import tccb_pkg::*;

  localparam int TEXT_COLS    = 40;
  localparam int TEXT_ROWS    = 40;
  localparam int CELL_TOTAL   = TEXT_ROWS * TEXT_COLS;
  // A form feed blanks the whole store, so give the tail that long and some.
  localparam int TAIL_CYCLES  = CELL_TOTAL + 100;
  // A form feed is the slowest item; a run where every item is a form feed
  // still ends several times below this.
  localparam int LIMIT_CYCLES = 20_000_000;
  localparam int RANDOM_ITEMS = 1830;
  localparam int PHASE_ITEMS  = 600;

  // Shadow copy of the console: cell store, circular top row and cursor.
  // Every accepted transfer advances it and queues the result it must cause.
  class console_mirror;
    logic [7:0]  cells [CELL_TOTAL];
    int unsigned top_phys;
    int unsigned cur_col;
    int unsigned cur_line;
    result_t     awaited_results [$];
    int unsigned mismatch_count;

    function new();
      mismatch_count = 0;
      blank_screen();
    endfunction

    function void blank_screen();
      foreach (cells[i]) cells[i] = SPACE_CODE;
      top_phys = 0;
      cur_col  = 0;
      cur_line = 0;
    endfunction

    function int unsigned cell_at(int unsigned row, int unsigned col);
      return ((top_phys + row) % TEXT_ROWS) * TEXT_COLS + col;
    endfunction

    // Home the column and step down; at the bottom, blank the old top row and
    // rotate it to the bottom. Return 1 when the screen scrolled.
    function bit line_down();
      int c;
      cur_col = 0;
      if (cur_line + 1 >= TEXT_ROWS) begin
        cur_line = TEXT_ROWS - 1;
        for (c = 0; c < TEXT_COLS; c++) cells[top_phys * TEXT_COLS + c] = SPACE_CODE;
        top_phys = (top_phys + 1) % TEXT_ROWS;
        return 1'b1;
      end
      cur_line++;
      return 1'b0;
    endfunction

    function void note_transfer(item_t it);
      result_t r;
      r = '0;
      if (it.operation == OP_READ) begin
        if (it.read_row < TEXT_ROWS && it.read_col < TEXT_COLS) begin
          r.cell_char = cells[cell_at(it.read_row, it.read_col)];
          if (r.cell_char >= SPACE_CODE && r.cell_char <= GLYPH_LAST)
            r.glyph_index = 7'(r.cell_char - SPACE_CODE);
        end
      end else begin
        case (it.char_code)
          CODE_CR: cur_col = 0;
          CODE_LF: r.redraw_all = line_down();
          CODE_BS, CODE_DEL: begin
            if (cur_col > 0) begin
              cur_col--;
              cells[cell_at(cur_line, cur_col)] = SPACE_CODE;
              r.redraw_one = 1'b1;
              r.redraw_row = 6'(cur_line);
            end
          end
          CODE_FF: begin
            blank_screen();
            r.redraw_all = 1'b1;
          end
          default: begin
            // Control codes below space fall through here and change nothing.
            if (it.char_code >= SPACE_CODE) begin
              cells[cell_at(cur_line, cur_col)] = it.char_code;
              r.redraw_one = 1'b1;
              r.redraw_row = 6'(cur_line);
              cur_col++;
              // Wrapping off the bottom line scrolls: a full redraw replaces
              // the single-row one.
              if (cur_col >= TEXT_COLS && line_down()) begin
                r.redraw_all = 1'b1;
                r.redraw_one = 1'b0;
                r.redraw_row = '0;
              end
            end
          end
        endcase
      end
      r.cursor_col = 6'(cur_col);
      r.cursor_row = 6'(cur_line);
      awaited_results.push_back(r);
    endfunction

    function void flag(string field, logic [7:0] want, logic [7:0] got);
      $display("%0t mismatch on %s: expected %h, actual %h", $time, field, want, got);
      mismatch_count++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t result with nothing pending: expected none, actual %h", $time, got);
        mismatch_count++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.redraw_one  !== want.redraw_one)
        flag("redraw_one", 8'(want.redraw_one), 8'(got.redraw_one));
      if (got.redraw_row  !== want.redraw_row)
        flag("redraw_row", 8'(want.redraw_row), 8'(got.redraw_row));
      if (got.redraw_all  !== want.redraw_all)
        flag("redraw_all", 8'(want.redraw_all), 8'(got.redraw_all));
      if (got.cursor_col  !== want.cursor_col)
        flag("cursor_col", 8'(want.cursor_col), 8'(got.cursor_col));
      if (got.cursor_row  !== want.cursor_row)
        flag("cursor_row", 8'(want.cursor_row), 8'(got.cursor_row));
      if (got.cell_char   !== want.cell_char)   flag("cell_char", want.cell_char, got.cell_char);
      if (got.glyph_index !== want.glyph_index)
        flag("glyph_index", 8'(want.glyph_index), 8'(got.glyph_index));
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    done;
  result_t result;

  console_mirror mirror;
  int unsigned   send_idle_pct = 0;
  int unsigned   cycle_count   = 0;

  always #6 clk = ~clk;

  text_console_cell_buffer_core #(
    .TEXT_COLS(TEXT_COLS),
    .TEXT_ROWS(TEXT_ROWS)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  // Watch both sides at each rising edge. Blocking reads here see the values
  // that the edge itself sampled, since every drive lands in the NBA region.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) mirror.note_transfer(item);
      if (done) mirror.check_result(result);
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Build a put; the read coordinates ride along as random noise.
  function automatic item_t put_item(logic [7:0] code);
    item_t it;
    it.operation = OP_PUT;
    it.char_code = code;
    it.read_row  = 6'($urandom_range(63));
    it.read_col  = 6'($urandom_range(63));
    return it;
  endfunction

  // Build a read; the character byte is random noise.
  function automatic item_t read_item(int unsigned row, int unsigned col);
    item_t it;
    it.operation = OP_READ;
    it.char_code = 8'($urandom_range(255));
    it.read_row  = 6'(row);
    it.read_col  = 6'(col);
    return it;
  endfunction

  function automatic item_t random_item();
    int unsigned pick;
    int unsigned row;
    int unsigned col;
    pick = $urandom_range(199);
    // Mostly in-range reads; the rest reach all 6 bits of both coordinates.
    row = ($urandom_range(99) < 85) ? $urandom_range(TEXT_ROWS - 1) : $urandom_range(63);
    col = ($urandom_range(99) < 85) ? $urandom_range(TEXT_COLS - 1) : $urandom_range(63);
    if (pick < 60)  return read_item(row, col);
    if (pick < 140) return put_item(8'($urandom_range(SPACE_CODE, 255)));
    if (pick < 156) return put_item(($urandom_range(1) != 0) ? CODE_BS : CODE_DEL);
    if (pick < 168) return put_item(CODE_CR);
    if (pick < 180) return put_item(CODE_LF);
    if (pick < 197) return put_item(8'($urandom_range(SPACE_CODE - 1)));
    return put_item(CODE_FF);
  endfunction

  // Drive one item and hold it until the block takes the transfer. Drop start
  // for a random gap first, at the rate set for the current phase.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
  endtask

  // Mix single random items with well-formed runs: line-feed bursts that push
  // the cursor to the bottom, full lines of text that wrap and scroll, and
  // read-back sweeps across a row.
  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned run_len;
    int unsigned row;
    int unsigned col;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        run_len = $urandom_range(1, TEXT_ROWS + 5);
        repeat (run_len) send_item(put_item(CODE_LF));
      end else if (pick < 11) begin
        run_len = $urandom_range(TEXT_COLS - 3, TEXT_COLS + 3);
        repeat (run_len) send_item(put_item(8'($urandom_range(SPACE_CODE, 255))));
      end else if (pick < 17) begin
        run_len = $urandom_range(4, 12);
        row = $urandom_range(TEXT_ROWS - 1);
        col = $urandom_range(TEXT_COLS - 1);
        repeat (run_len) begin
          send_item(read_item(row, col));
          col = (col + 1) % TEXT_COLS;
        end
      end else begin
        run_len = 1;
        send_item(random_item());
      end
      sent += run_len;
    end
  endtask

  initial begin
    mirror = new();
    rst    = 1'b1;
    start  = 1'b0;
    item   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 38;
    // Directed: corners of the read window, out-of-range reads, glyph edges,
    // erase with and without room, ignored controls, line feed, form feed.
    send_item(read_item(0, 0));
    send_item(read_item(TEXT_ROWS - 1, TEXT_COLS - 1));
    send_item(read_item(TEXT_ROWS, 0));
    send_item(read_item(0, TEXT_COLS));
    send_item(read_item(63, 63));
    send_item(put_item(8'd65));
    send_item(put_item(8'd255));
    send_item(put_item(GLYPH_LAST));
    send_item(put_item(GLYPH_LAST + 8'd1));
    send_item(read_item(0, 0));
    send_item(read_item(0, 1));
    send_item(read_item(0, 2));
    send_item(read_item(0, 3));
    send_item(put_item(CODE_BS));
    send_item(put_item(CODE_DEL));
    send_item(put_item(CODE_CR));
    send_item(put_item(CODE_BS));
    send_item(put_item(8'd0));
    send_item(put_item(SPACE_CODE - 8'd1));
    send_item(put_item(CODE_LF));
    send_item(put_item(8'd128));
    send_item(read_item(1, 0));
    send_item(put_item(CODE_FF));
    send_item(read_item(1, 0));

    // Random: sender idles often, then very often, then never.
    run_random(PHASE_ITEMS);
    send_idle_pct = 72;
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    run_random(RANDOM_ITEMS - 2 * PHASE_ITEMS);
    start <= 1'b0;

    // Drain: wait out every pending result, then watch for strays.
    while (mirror.awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mirror.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
design/tccb_pkg.sv
design/tccb_front.sv
design/tccb_queue.sv
design/tccb_back.sv
design/text_console_cell_buffer_core.sv
tb/tb_top.sv
